FILE: sv/psdq_pkg.sv
// Shared constants, codes and the sequencer state type of the polygon distance query block.
package psdq_pkg;

   // Coordinate and table sizes.
   localparam int CW   = 32;
   localparam int MAXV = 64;
   localparam int AW   = 6;
   localparam int CNTW = 7;

   // Shared multiplier operand width and product width.
   localparam int MW = 36;
   localparam int PW = 72;

   // Divider working width and quotient width.
   localparam int DW = 102;
   localparam int QW = 35;

   localparam logic [CNTW-1:0] MAX_COUNT = CNTW'(MAXV);
   localparam logic signed [CW-1:0] DIST_LIMIT = {1'b0, {(CW-1){1'b1}}};
   localparam logic [5:0] TOP_BIT = 6'd34;

   // Command codes.
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Status codes.
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_EMPTY   = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;
   localparam logic [1:0] STAT_CLEARED = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD,
      ST_LD,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_M4,
      ST_M5,
      ST_M6,
      ST_PROJ,
      ST_N0,
      ST_N1,
      ST_N2,
      ST_DIV,
      ST_ADJ,
      ST_DD,
      ST_DX,
      ST_DY,
      ST_CMP,
      ST_ADV,
      ST_SQI,
      ST_SQM,
      ST_SQC,
      ST_FIN,
      ST_OUT
   } state_type;

endpackage

FILE: sv/polygon_signed_distance_query.sv
// Polygon signed-distance query block: vertex table, bounding box and query sequencer.
//
// A clear, an add and a query on an empty polygon go straight to the response hand-off.
// Any other query walks every edge once: an edge is read, measured with the shared
// multiplier and then skipped, resolved to an end point, or, when the point projects
// inside the edge, resolved by a 35-step serial division on each axis. After the walk, a
// 35-step square root runs when any edge was kept, and the response is then handed out.
// The single shared 36 x 36 multiplier has a registered product, and the divider
// yields one quotient bit per cycle.
// The block accepts no request while a command is in progress, but it takes a new
// one while the previous response is still waiting to be taken.
module polygon_signed_distance_query
   import psdq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_cmd,
   input  logic signed [CW-1:0] req_coord_x,
   input  logic signed [CW-1:0] req_coord_y,
   input  logic                 req_skip_axis_edges,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_inside_res,
   output logic signed [CW-1:0] rsp_signed_distance,
   output logic signed [CW-1:0] rsp_nearest_x,
   output logic signed [CW-1:0] rsp_nearest_y,
   output logic [AW-1:0]        rsp_vertex_index,
   output logic [1:0]           rsp_status
);

   state_type state_ff, state_in;

   // Vertex tables and their registered read ports.
   logic signed [CW-1:0] vx_mem [MAXV];
   logic signed [CW-1:0] vy_mem [MAXV];
   logic signed [CW-1:0] x1_rd_ff, y1_rd_ff, x2_rd_ff, y2_rd_ff;

   logic [CNTW-1:0]      count_ff;
   logic signed [CW-1:0] box_min_x_ff, box_min_y_ff, box_max_x_ff, box_max_y_ff;

   // Query working registers.
   logic signed [CW-1:0] px_ff, py_ff;
   logic                 skip_ff, box_ok_ff, parity_ff, found_ff, axis_ff;
   logic                 cross_ff, skip_edge_ff;
   logic [AW-1:0]        p1_ff;
   logic [AW-1:0]        p2;
   logic signed [CW:0]   ex_ff, ey_ff, wx_ff, wy_ff, ax_ff, by_ff, dxr_ff, dyr_ff;
   logic signed [PW-1:0] prod_ff, acc_ff, d2_ff, dot_ff, pa_ff, best_ff;
   logic signed [PW-1:0] sum_p;
   logic [DW-1:0]        num_ff, dsh_ff;
   logic [QW-1:0]        q_ff, r_ff, sq_cand;
   logic [5:0]           cnt_ff;
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic signed [MW-1:0] mul_a, mul_b;
   logic [CW:0]          em;
   logic signed [MW-1:0] x_base, q_ext, adj_sum;

   // Pending response and output register.
   logic                 res_inside_ff;
   logic signed [CW-1:0] res_dist_ff, res_nx_ff, res_ny_ff;
   logic [AW-1:0]        res_index_ff;
   logic [1:0]           res_status_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_inside_ff;
   logic signed [CW-1:0] rsp_dist_ff, rsp_nx_ff, rsp_ny_ff;
   logic [AW-1:0]        rsp_index_ff;
   logic [1:0]           rsp_status_ff;

   logic                 req_take;
   logic                 out_free;
   logic                 last_edge;
   logic [QW-1:0]        mag;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_inside_res      = rsp_inside_ff;
   assign rsp_signed_distance = rsp_dist_ff;
   assign rsp_nearest_x       = rsp_nx_ff;
   assign rsp_nearest_y       = rsp_ny_ff;
   assign rsp_vertex_index    = rsp_index_ff;
   assign rsp_status          = rsp_status_ff;

   // Second vertex of the current edge wraps to the first.
   assign p2 = (({1'b0, p1_ff} + CNTW'(1)) == count_ff) ? '0 : p1_ff + AW'(1);
   assign last_edge = (({1'b0, p1_ff} + CNTW'(1)) == count_ff);

   // Table write on add and the two registered read ports.
   always_ff @(posedge clock) begin
      if (req_take && req_cmd == CMD_ADD && count_ff < MAX_COUNT) begin
         vx_mem[count_ff[AW-1:0]] <= req_coord_x;
         vy_mem[count_ff[AW-1:0]] <= req_coord_y;
      end
      x1_rd_ff <= vx_mem[p1_ff];
      y1_rd_ff <= vy_mem[p1_ff];
      x2_rd_ff <= vx_mem[p2];
      y2_rd_ff <= vy_mem[p2];
   end

   // Operand select for the shared multiplier.
   assign em = axis_ff ? (ey_ff[CW] ? (CW+1)'(-ey_ff) : ey_ff)
                       : (ex_ff[CW] ? (CW+1)'(-ex_ff) : ex_ff);
   assign sq_cand = r_ff | (QW'(1) << cnt_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_M1: begin
            mul_a = {{3{ex_ff[CW]}}, ex_ff};
            mul_b = {{3{ex_ff[CW]}}, ex_ff};
         end
         ST_M2: begin
            mul_a = {{3{ey_ff[CW]}}, ey_ff};
            mul_b = {{3{ey_ff[CW]}}, ey_ff};
         end
         ST_M3: begin
            mul_a = {{3{wx_ff[CW]}}, wx_ff};
            mul_b = {{3{ex_ff[CW]}}, ex_ff};
         end
         ST_M4: begin
            mul_a = {{3{wy_ff[CW]}}, wy_ff};
            mul_b = {{3{ey_ff[CW]}}, ey_ff};
         end
         ST_M5: begin
            mul_a = {{3{ax_ff[CW]}}, ax_ff};
            mul_b = {{3{ey_ff[CW]}}, ey_ff};
         end
         ST_M6: begin
            mul_a = {{3{ex_ff[CW]}}, ex_ff};
            mul_b = {{3{by_ff[CW]}}, by_ff};
         end
         ST_N0: begin
            mul_a = {3'b0, dot_ff[32:0]};
            mul_b = {3'b0, em};
         end
         ST_N1: begin
            mul_a = {2'b0, dot_ff[66:33]};
            mul_b = {3'b0, em};
         end
         ST_DX: begin
            mul_a = {{3{dxr_ff[CW]}}, dxr_ff};
            mul_b = {{3{dxr_ff[CW]}}, dxr_ff};
         end
         ST_DY: begin
            mul_a = {{3{dyr_ff[CW]}}, dyr_ff};
            mul_b = {{3{dyr_ff[CW]}}, dyr_ff};
         end
         ST_SQM: begin
            mul_a = {1'b0, sq_cand};
            mul_b = {1'b0, sq_cand};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign sum_p = acc_ff + prod_ff;

   // Projection offset applied to the first vertex of the edge.
   assign x_base  = axis_ff ? {{4{y1_rd_ff[CW-1]}}, y1_rd_ff} : {{4{x1_rd_ff[CW-1]}}, x1_rd_ff};
   assign q_ext   = {1'b0, q_ff};
   assign adj_sum = (axis_ff ? ey_ff[CW] : ex_ff[CW]) ? x_base - q_ext : x_base + q_ext;

   assign mag = (r_ff > QW'(DIST_LIMIT)) ? QW'(DIST_LIMIT) : r_ff;

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_cmd inside {CMD_CLEAR, CMD_ADD}) begin
                  state_in = ST_OUT;
               end else if (req_cmd == CMD_QUERY) begin
                  state_in = (count_ff == '0) ? ST_OUT : ST_RD;
               end
            end
         end
         ST_RD:   state_in = ST_LD;
         ST_LD:   state_in = ST_M1;
         ST_M1:   state_in = ST_M2;
         ST_M2:   state_in = ST_M3;
         ST_M3:   state_in = ST_M4;
         ST_M4:   state_in = ST_M5;
         ST_M5:   state_in = ST_M6;
         ST_M6:   state_in = ST_PROJ;
         ST_PROJ: begin
            if (skip_edge_ff) begin
               state_in = ST_ADV;
            end else if (d2_ff == '0 || dot_ff <= PW'(0) || dot_ff >= d2_ff) begin
               state_in = ST_DD;
            end else begin
               state_in = ST_N0;
            end
         end
         ST_N0:   state_in = ST_N1;
         ST_N1:   state_in = ST_N2;
         ST_N2:   state_in = ST_DIV;
         ST_DIV:  state_in = (cnt_ff == '0) ? ST_ADJ : ST_DIV;
         ST_ADJ:  state_in = axis_ff ? ST_DD : ST_N0;
         ST_DD:   state_in = ST_DX;
         ST_DX:   state_in = ST_DY;
         ST_DY:   state_in = ST_CMP;
         ST_CMP:  state_in = ST_ADV;
         ST_ADV:  state_in = last_edge ? ST_SQI : ST_RD;
         ST_SQI:  state_in = found_ff ? ST_SQM : ST_FIN;
         ST_SQM:  state_in = ST_SQC;
         ST_SQC:  state_in = (cnt_ff == '0) ? ST_FIN : ST_SQM;
         ST_FIN:  state_in = ST_OUT;
         ST_OUT:  state_in = out_free ? ST_IDLE : ST_OUT;
         default: state_in = ST_IDLE;
      endcase
   end

   // Vertex count and bounding box.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         box_min_x_ff <= '0;
         box_min_y_ff <= '0;
         box_max_x_ff <= '0;
         box_max_y_ff <= '0;
      end else if (req_take && req_cmd == CMD_CLEAR) begin
         count_ff     <= '0;
         box_min_x_ff <= '0;
         box_min_y_ff <= '0;
         box_max_x_ff <= '0;
         box_max_y_ff <= '0;
      end else if (req_take && req_cmd == CMD_ADD && count_ff < MAX_COUNT) begin
         count_ff <= count_ff + CNTW'(1);
         if (count_ff == '0) begin
            box_min_x_ff <= req_coord_x;
            box_max_x_ff <= req_coord_x;
            box_min_y_ff <= req_coord_y;
            box_max_y_ff <= req_coord_y;
         end else begin
            if (req_coord_x < box_min_x_ff) box_min_x_ff <= req_coord_x;
            if (req_coord_x > box_max_x_ff) box_max_x_ff <= req_coord_x;
            if (req_coord_y < box_min_y_ff) box_min_y_ff <= req_coord_y;
            if (req_coord_y > box_max_y_ff) box_max_y_ff <= req_coord_y;
         end
      end
   end

   // Shared multiplier with registered product.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // Datapath registers stepped by the sequencer.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               px_ff     <= req_coord_x;
               py_ff     <= req_coord_y;
               skip_ff   <= req_skip_axis_edges;
               p1_ff     <= '0;
               parity_ff <= 1'b0;
               found_ff  <= 1'b0;
               box_ok_ff <= !(req_coord_x < box_min_x_ff || req_coord_x > box_max_x_ff ||
                              req_coord_y < box_min_y_ff || req_coord_y > box_max_y_ff);
               res_inside_ff <= 1'b0;
               res_nx_ff     <= '0;
               res_ny_ff     <= '0;
               res_dist_ff   <= (req_cmd == CMD_QUERY && count_ff == '0) ? DIST_LIMIT : '0;
               res_index_ff  <= (req_cmd == CMD_ADD && count_ff < MAX_COUNT) ?
                                count_ff[AW-1:0] : '0;
               case (req_cmd)
                  CMD_CLEAR: res_status_ff <= STAT_CLEARED;
                  CMD_ADD:   res_status_ff <= (count_ff < MAX_COUNT) ? STAT_OK : STAT_FULL;
                  CMD_QUERY: res_status_ff <= (count_ff == '0) ? STAT_EMPTY : STAT_OK;
                  default:   res_status_ff <= STAT_OK;
               endcase
            end
         end
         ST_LD: begin
            // Edge vectors, crossing test inputs and the skip decision.
            ex_ff <= {x2_rd_ff[CW-1], x2_rd_ff} - {x1_rd_ff[CW-1], x1_rd_ff};
            ey_ff <= {y2_rd_ff[CW-1], y2_rd_ff} - {y1_rd_ff[CW-1], y1_rd_ff};
            wx_ff <= {px_ff[CW-1], px_ff} - {x1_rd_ff[CW-1], x1_rd_ff};
            wy_ff <= {py_ff[CW-1], py_ff} - {y1_rd_ff[CW-1], y1_rd_ff};
            ax_ff <= {px_ff[CW-1], px_ff} - {x2_rd_ff[CW-1], x2_rd_ff};
            by_ff <= {py_ff[CW-1], py_ff} - {y2_rd_ff[CW-1], y2_rd_ff};
            cross_ff     <= (y2_rd_ff > py_ff) != (y1_rd_ff > py_ff);
            skip_edge_ff <= skip_ff && x1_rd_ff == '0 && x2_rd_ff == '0;
            axis_ff      <= 1'b0;
         end
         ST_M2: acc_ff <= prod_ff;
         ST_M3: d2_ff  <= sum_p;
         ST_M4: acc_ff <= prod_ff;
         ST_M5: dot_ff <= sum_p;
         ST_M6: pa_ff  <= prod_ff;
         ST_PROJ: begin
            // Even-odd crossing toggle; the edge runs from the later vertex back.
            if (cross_ff && (ey_ff[CW] ? (pa_ff > prod_ff) : (pa_ff < prod_ff))) begin
               parity_ff <= !parity_ff;
            end
            if (d2_ff != '0 && dot_ff > PW'(0) && dot_ff >= d2_ff) begin
               cx_ff <= x2_rd_ff;
               cy_ff <= y2_rd_ff;
            end else begin
               cx_ff <= x1_rd_ff;
               cy_ff <= y1_rd_ff;
            end
         end
         ST_N1: num_ff <= {{(DW-PW){1'b0}}, prod_ff};
         ST_N2: begin
            num_ff <= num_ff + ({{(DW-PW){1'b0}}, prod_ff} << 33);
            dsh_ff <= {d2_ff[67:0], 34'b0};
            q_ff   <= '0;
            cnt_ff <= TOP_BIT;
         end
         ST_DIV: begin
            // One quotient bit per cycle.
            if (dsh_ff <= num_ff) begin
               num_ff <= num_ff - dsh_ff;
               q_ff   <= q_ff | (QW'(1) << cnt_ff);
            end
            dsh_ff <= dsh_ff >> 1;
            if (cnt_ff != '0) cnt_ff <= cnt_ff - 6'd1;
         end
         ST_ADJ: begin
            if (axis_ff) begin
               cy_ff <= adj_sum[CW-1:0];
            end else begin
               cx_ff <= adj_sum[CW-1:0];
            end
            axis_ff <= 1'b1;
         end
         ST_DD: begin
            dxr_ff <= {px_ff[CW-1], px_ff} - {cx_ff[CW-1], cx_ff};
            dyr_ff <= {py_ff[CW-1], py_ff} - {cy_ff[CW-1], cy_ff};
         end
         ST_DY: acc_ff <= prod_ff;
         ST_CMP: begin
            // The first edge wins on equal distances.
            if (!found_ff || sum_p < best_ff) begin
               found_ff  <= 1'b1;
               best_ff   <= sum_p;
               res_nx_ff <= cx_ff;
               res_ny_ff <= cy_ff;
            end
         end
         ST_ADV: p1_ff <= p1_ff + AW'(1);
         ST_SQI: begin
            r_ff   <= found_ff ? '0 : QW'(DIST_LIMIT);
            cnt_ff <= TOP_BIT;
         end
         ST_SQC: begin
            // Keep the trial root bit when its square still fits.
            if (prod_ff <= best_ff) r_ff <= sq_cand;
            if (cnt_ff != '0) cnt_ff <= cnt_ff - 6'd1;
         end
         ST_FIN: begin
            res_inside_ff <= box_ok_ff && parity_ff;
            res_dist_ff   <= (box_ok_ff && parity_ff) ? -CW'(mag) : CW'(mag);
         end
         default: begin
         end
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_inside_ff <= res_inside_ff;
         rsp_dist_ff   <= res_dist_ff;
         rsp_nx_ff     <= res_nx_ff;
         rsp_ny_ff     <= res_ny_ff;
         rsp_index_ff  <= res_index_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   // The table never holds more than its capacity.
   assert property (@(posedge clock) disable iff (reset) count_ff <= MAX_COUNT)
      else $error("vertex count beyond table size");

   // The edge walk only reads entries below the count.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD |-> {1'b0, p1_ff} < count_ff)
      else $error("edge walk past the vertex count");

   // A new response appears only out of the hand-off state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("response raised outside hand-off");

   // An inside result always carries a non-positive distance.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_inside_ff |-> rsp_dist_ff <= 0)
      else $error("inside point with positive distance");

endmodule

FILE: verif/psdq_checker.sv
// Checker for the polygon distance query block: predicts each response and compares it.
module psdq_checker
   import psdq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [1:0]           req_cmd,
   input  logic signed [CW-1:0] req_coord_x,
   input  logic signed [CW-1:0] req_coord_y,
   input  logic                 req_skip_axis_edges,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_inside_res,
   input  logic signed [CW-1:0] rsp_signed_distance,
   input  logic signed [CW-1:0] rsp_nearest_x,
   input  logic signed [CW-1:0] rsp_nearest_y,
   input  logic [AW-1:0]        rsp_vertex_index,
   input  logic [1:0]           rsp_status,
   output int                   errors,
   output int                   outstanding
);

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic          in_poly;
      logic [CW-1:0] distance;
      logic [CW-1:0] near_x;
      logic [CW-1:0] near_y;
      logic [AW-1:0] index;
      logic [1:0]    status;
   } answer_type;

   // Polygon as the block should hold it.
   wide_type        poly_x [MAXV];
   wide_type        poly_y [MAXV];
   int              poly_count;
   wide_type        lo_x, lo_y, hi_x, hi_y;
   answer_type      pending_answers [$];

   // Closest point on the edge from vertex a to vertex b.
   function automatic void edge_nearest(input int a, input int b, input wide_type px,
                                        input wide_type py, output wide_type cx,
                                        output wide_type cy);
      wide_type ex, ey, len2, dot, mag;
      ex = poly_x[b] - poly_x[a];
      ey = poly_y[b] - poly_y[a];
      len2 = ex * ex + ey * ey;
      cx = poly_x[a];
      cy = poly_y[a];
      if (len2 == 0) return;
      dot = (px - poly_x[a]) * ex + (py - poly_y[a]) * ey;
      if (dot <= 0) return;
      if (dot >= len2) begin
         cx = poly_x[b];
         cy = poly_y[b];
         return;
      end
      // Offsets are truncated toward zero and take the sign of the edge direction.
      mag = (ex < 0) ? -ex : ex;
      mag = dot * mag / len2;
      cx = poly_x[a] + ((ex < 0) ? -mag : mag);
      mag = (ey < 0) ? -ey : ey;
      mag = dot * mag / len2;
      cy = poly_y[a] + ((ey < 0) ? -mag : mag);
   endfunction

   // Even-odd crossing rule behind a bounding box test.
   function automatic logic crossing_inside(input wide_type px, input wide_type py);
      logic     odd;
      int       j;
      wide_type dy, lhs, rhs;
      odd = 1'b0;
      if (px < lo_x || px > hi_x || py < lo_y || py > hi_y || poly_count == 0) return 1'b0;
      j = poly_count - 1;
      for (int i = 0; i < poly_count; i++) begin
         if ((poly_y[i] > py) != (poly_y[j] > py)) begin
            dy  = poly_y[j] - poly_y[i];
            lhs = (px - poly_x[i]) * dy;
            rhs = (poly_x[j] - poly_x[i]) * (py - poly_y[i]);
            if (dy > 0 ? lhs < rhs : lhs > rhs) odd = !odd;
         end
         j = i;
      end
      return odd;
   endfunction

   // Floor of the square root, 35 result bits.
   function automatic wide_type root_floor(input wide_type v);
      wide_type r, c;
      r = 0;
      for (int b = 34; b >= 0; b--) begin
         c = r | (wide_type'(1) << b);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   // Expected response to one request; also advances the predicted polygon.
   function automatic answer_type predict_answer(input logic [1:0] cmd, input wide_type px,
                                                 input wide_type py, input logic skip);
      answer_type ans;
      wide_type   best, d, cx, cy, bx, by, mag, lim;
      logic       found, ins;
      int         k;
      ans = '0;
      lim = wide_type'(DIST_LIMIT);
      case (cmd)
         CMD_CLEAR: begin
            poly_count = 0;
            lo_x = 0; lo_y = 0; hi_x = 0; hi_y = 0;
            ans.status = STAT_CLEARED;
         end
         CMD_ADD: begin
            if (poly_count >= MAXV) begin
               ans.status = STAT_FULL;
            end else begin
               poly_x[poly_count] = px;
               poly_y[poly_count] = py;
               if (poly_count == 0) begin
                  lo_x = px; hi_x = px; lo_y = py; hi_y = py;
               end else begin
                  if (px < lo_x) lo_x = px;
                  if (px > hi_x) hi_x = px;
                  if (py < lo_y) lo_y = py;
                  if (py > hi_y) hi_y = py;
               end
               ans.index = AW'(poly_count);
               poly_count++;
            end
         end
         default: begin
            if (poly_count == 0) begin
               ans.distance = DIST_LIMIT;
               ans.status   = STAT_EMPTY;
            end else begin
               found = 1'b0;
               best = 0; bx = 0; by = 0;
               for (int p = 0; p < poly_count; p++) begin
                  k = (p + 1 == poly_count) ? 0 : p + 1;
                  if (skip && poly_x[p] == 0 && poly_x[k] == 0) continue;
                  edge_nearest(p, k, px, py, cx, cy);
                  d = (px - cx) * (px - cx) + (py - cy) * (py - cy);
                  // Ties keep the earlier edge.
                  if (!found || d < best) begin
                     found = 1'b1; best = d; bx = cx; by = cy;
                  end
               end
               ins = crossing_inside(px, py);
               mag = found ? root_floor(best) : lim;
               if (mag > lim) mag = lim;
               ans.in_poly  = ins;
               ans.distance = CW'(ins ? -mag : mag);
               ans.near_x   = CW'(bx);
               ans.near_y   = CW'(by);
            end
         end
      endcase
      return ans;
   endfunction

   task automatic report_field(input string name, input logic [CW-1:0] want,
                               input logic [CW-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // Watch both channels at each rising edge.
   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         poly_count = 0;
         lo_x = 0; lo_y = 0; hi_x = 0; hi_y = 0;
         pending_answers.delete();
         errors = 0;
      end else begin
         if (req_valid && !req_stall && req_cmd != CMD_UNUSED)
            pending_answers = {pending_answers,
                               predict_answer(req_cmd, wide_type'(req_coord_x),
                                              wide_type'(req_coord_y),
                                              req_skip_axis_edges)};
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               $display("%0t: unexpected response, expected none actual status %h",
                        $time, rsp_status);
               errors++;
            end else begin
               want = pending_answers.pop_front();
               report_field("inside_res", CW'(want.in_poly), CW'(rsp_inside_res));
               report_field("signed_distance", want.distance, rsp_signed_distance);
               report_field("nearest_x", want.near_x, rsp_nearest_x);
               report_field("nearest_y", want.near_y, rsp_nearest_y);
               report_field("vertex_index", CW'(want.index), CW'(rsp_vertex_index));
               report_field("status", CW'(want.status), CW'(rsp_status));
            end
         end
      end
      outstanding = pending_answers.size();
   end

endmodule

FILE: verif/tb_polygon_signed_distance_query.sv
// Testbench top for the polygon distance query block: clock, reset, stimulus and verdict.
module tb_polygon_signed_distance_query;
   import psdq_pkg::*;

   localparam int IDLE_LIMIT = 40000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_cmd;
   logic signed [CW-1:0] req_coord_x;
   logic signed [CW-1:0] req_coord_y;
   logic                 req_skip_axis_edges;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_inside_res;
   logic signed [CW-1:0] rsp_signed_distance;
   logic signed [CW-1:0] rsp_nearest_x;
   logic signed [CW-1:0] rsp_nearest_y;
   logic [AW-1:0]        rsp_vertex_index;
   logic [1:0]           rsp_status;
   int                   errors;
   int                   outstanding;
   int                   idle_cycles;
   int                   stall_left;
   logic                 quiet;

   polygon_signed_distance_query dut (.*);
   psdq_checker scoreboard (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom_range(0, 2);
      if (r < 9) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // Small coordinates near the origin dominate; zeros, extremes and full-range values mix in.
   function automatic logic [CW-1:0] pick_coord();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return '0;
         1: return $urandom();
         2: begin
            case ($urandom_range(0, 4))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0000_0001;
               3: return 32'hffff_ffff;
               default: return 32'h0001_0000;
            endcase
         end
         default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      endcase
   endfunction

   // Receiver stalls.
   always @(posedge clock) begin
      if (reset || quiet) begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left <= gap_length();
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog on cycles with no handshake on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Present one request and hold it until it is taken.
   task automatic send_request(input logic [1:0] cmd, input logic [CW-1:0] x,
                               input logic [CW-1:0] y, input logic skip);
      req_valid           <= 1'b1;
      req_cmd             <= cmd;
      req_coord_x         <= x;
      req_coord_y         <= y;
      req_skip_axis_edges <= skip;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic sender_gap();
      int n;
      n = quiet ? 0 : gap_length();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      int items;
      int n_add;
      int n_query;
      logic [1:0] pick;
      items = 0;
      quiet = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_CLEAR;
      req_coord_x = '0;
      req_coord_y = '0;
      req_skip_axis_edges = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty polygon, ignored command, a triangle with an edge on the y axis.
      send_request(CMD_QUERY, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
      sender_gap();
      send_request(CMD_UNUSED, 32'h1234_5678, 32'h8765_4321, 1'b1);
      send_request(CMD_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
      send_request(CMD_ADD, 32'h0000_0000, 32'hfffe_0000, 1'b0);
      send_request(CMD_ADD, 32'h0000_0000, 32'h0002_0000, 1'b0);
      send_request(CMD_ADD, 32'h0003_0000, 32'h0000_0000, 1'b0);
      sender_gap();
      send_request(CMD_QUERY, 32'h0000_8000, 32'h0000_0000, 1'b0);
      send_request(CMD_QUERY, 32'h0000_8000, 32'h0000_0000, 1'b1);
      send_request(CMD_QUERY, 32'hfff0_0000, 32'h0005_0000, 1'b0);
      send_request(CMD_QUERY, 32'h0003_0000, 32'h0000_0000, 1'b0);
      // Equidistant from the edges that meet at the nearest vertex.
      send_request(CMD_QUERY, 32'h0004_0000, 32'h0000_0000, 1'b0);
      // Extreme vertices and a repeated one make a degenerate edge.
      send_request(CMD_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
      send_request(CMD_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
      send_request(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 1'b0);
      send_request(CMD_QUERY, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
      send_request(CMD_QUERY, 32'h0000_0000, 32'h0000_0000, 1'b1);
      // Only axis edges; the first query skips them all, the second does not.
      send_request(CMD_CLEAR, 32'h0, 32'h0, 1'b0);
      send_request(CMD_ADD, 32'h0000_0000, 32'h0001_0000, 1'b0);
      send_request(CMD_ADD, 32'h0000_0000, 32'h8000_0000, 1'b0);
      send_request(CMD_QUERY, 32'h0001_0000, 32'h0000_0000, 1'b1);
      send_request(CMD_QUERY, 32'h0001_0000, 32'h0000_0000, 1'b0);
      items = 21;

      // Let every response arrive before going on.
      drain_responses();

      // Random polygons, each followed by queries, with some stray requests.
      while (items < 270) begin
         quiet = ($urandom_range(0, 4) == 0);
         send_request(CMD_CLEAR, $urandom(), $urandom(), $urandom_range(0, 1));
         items++;
         n_add = ($urandom_range(0, 14) == 0) ? $urandom_range(64, 66) : $urandom_range(1, 8);
         n_query = (n_add > 8) ? 2 : $urandom_range(2, 6);
         for (int i = 0; i < n_add; i++) begin
            sender_gap();
            send_request(CMD_ADD, pick_coord(), pick_coord(), $urandom_range(0, 1));
            items++;
         end
         for (int i = 0; i < n_query; i++) begin
            sender_gap();
            pick = 2'($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : CMD_QUERY);
            send_request(pick, pick_coord(), pick_coord(), $urandom_range(0, 1));
            if (pick != CMD_UNUSED) items++;
         end
         sender_gap();
      end
      quiet = 1'b0;

      drain_responses();
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
